/* rtl/lirs_pkg.sv */
// Shared types and constants of the linear interpolation stereo resampler.
package lirs_pkg;

   localparam int RATE_W   = 18;
   localparam int SAMPLE_W = 16;
   localparam int NUM_W    = 36;
   localparam int STEP_W   = 6;
   localparam int COUNT_W  = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [RATE_W-1:0]  DEFAULT_RATE = 18'd48000;
   localparam logic [RATE_W-1:0]  MIN_RATE     = 18'd8000;
   localparam logic [RATE_W-1:0]  MAX_RATE     = 18'd192000;
   localparam logic [RATE_W-1:0]  MAX_UP_RATIO = 18'd24;
   localparam logic [COUNT_W-1:0] MAX_RESULTS  = 6'd50;

   // The ratio of 24 splits into a shift by 3 and a division by 3, which is done by a
   // reciprocal multiplication that is exact for the rates in range.
   localparam int          UP_RATIO_SHIFT = 3;
   localparam logic [15:0] THIRD_RECIP    = 16'd43691;
   localparam int          THIRD_SHIFT    = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_RATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONO_SOURCE = 2'd3;

   typedef struct packed {
      logic                       first;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } req_entry_type;

   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

endpackage

/* rtl/lirs_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module lirs_div #(
   parameter int DIV_W = 43
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIV_W-1:0]            dividend,
   input  logic [lirs_pkg::RATE_W-1:0] divisor,
   output logic                        done,
   output logic [DIV_W-1:0]            quotient,
   output logic [lirs_pkg::RATE_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int RW    = lirs_pkg::RATE_W;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW-1:0]    dsr_ff, dsr_in;
   logic             done_ff, done_in;
   logic [RW:0]      rem_shift;
   logic [RW:0]      rem_diff;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      fits      = rem_shift >= {1'b0, dsr_ff};
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      done_in   = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(DIV_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? rem_diff[RW-1:0] : rem_shift[RW-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/lirs_queue.sv */
// Short word queue between the front and back parts of the resampler.
module lirs_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lirs_pkg::req_entry_type  push_entry,
   output logic                     full,
   output lirs_pkg::queue_head_type head,
   input  logic                     pop
);

   localparam int DEPTH = lirs_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   lirs_pkg::req_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = count_ff == (PTR_W + 1)'(DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = entries_ff[rd_ptr_ff];

endmodule

/* rtl/lirs_front.sv */
// Front part: configuration registers, input acceptance and frame classification.
module lirs_front #(
   parameter int FRAME_COUNT_BITS = 24,
   parameter int CSR_DATA_W       = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lirs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]            csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   output logic                             push,
   output lirs_pkg::req_entry_type          push_entry,
   input  logic                             queue_full,
   output logic [lirs_pkg::RATE_W-1:0]      eff_out,
   output logic [lirs_pkg::RATE_W-1:0]      src_raw,
   output logic [FRAME_COUNT_BITS-1:0]      frame_total
);

   localparam int RW  = lirs_pkg::RATE_W;
   localparam int FCB = FRAME_COUNT_BITS;

   logic [RW-1:0]  src_ff, src_in;
   logic [RW-1:0]  out_ff, out_in;
   logic [FCB-1:0] frames_ff, frames_in;
   logic           mono_ff, mono_in;
   logic [FCB-1:0] frame_idx_ff, frame_idx_in;
   logic [FCB:0]   frame_next;
   logic           csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   assign eff_out = (out_ff < lirs_pkg::MIN_RATE || out_ff > lirs_pkg::MAX_RATE)
                    ? lirs_pkg::DEFAULT_RATE : out_ff;
   assign src_raw     = (src_ff == '0) ? eff_out : src_ff;
   assign frame_total = (frames_ff == '0) ? FCB'(1) : frames_ff;

   assign push_entry.first = frame_idx_ff == '0;
   assign push_entry.left  = req_tdata[15:0];
   assign push_entry.right = mono_ff ? req_tdata[15:0] : req_tdata[31:16];

   always_comb begin
      src_in       = src_ff;
      out_in       = out_ff;
      frames_in    = frames_ff;
      mono_in      = mono_ff;
      frame_idx_in = frame_idx_ff;
      frame_next   = {1'b0, frame_idx_ff} + 1'b1;
      if (push) begin
         frame_idx_in = (frame_next >= {1'b0, frame_total}) ? '0 : frame_next[FCB-1:0];
      end
      if (csr_write) begin
         frame_idx_in = '0;
         case (csr_index)
            lirs_pkg::CSR_SOURCE_RATE: src_in    = csr_data[RW-1:0];
            lirs_pkg::CSR_OUTPUT_RATE: out_in    = csr_data[RW-1:0];
            lirs_pkg::CSR_FRAME_COUNT: frames_in = csr_data[FCB-1:0];
            lirs_pkg::CSR_MONO_SOURCE: mono_in   = csr_data[0];
            default: mono_in = mono_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff       <= '0;
         out_ff       <= lirs_pkg::DEFAULT_RATE;
         frames_ff    <= FCB'(1);
         mono_ff      <= 1'b0;
         frame_idx_ff <= '0;
      end else begin
         src_ff       <= src_in;
         out_ff       <= out_in;
         frames_ff    <= frames_in;
         mono_ff      <= mono_in;
         frame_idx_ff <= frame_idx_in;
      end
   end

endmodule

/* rtl/lirs_back.sv */
// Back part: clip setup, output position tracking and interpolation.
module lirs_back #(
   parameter int FRAME_COUNT_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lirs_pkg::queue_head_type    head,
   output logic                        pop,
   input  logic [lirs_pkg::RATE_W-1:0] eff_out,
   input  logic [lirs_pkg::RATE_W-1:0] src_raw,
   input  logic [FRAME_COUNT_BITS-1:0] frame_total,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int RW     = lirs_pkg::RATE_W;
   localparam int SW     = lirs_pkg::SAMPLE_W;
   localparam int NW     = lirs_pkg::NUM_W;
   localparam int STW    = lirs_pkg::STEP_W;
   localparam int CW     = lirs_pkg::COUNT_W;
   localparam int FCB    = FRAME_COUNT_BITS;
   localparam int TOT_W  = FCB + 5;
   localparam int PROD_W = FCB + RW;
   localparam int ADV_W  = FCB + STW + 1;
   localparam int DIV_W  = (FCB + 19 > NW) ? FCB + 19 : NW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SETUP_START, ST_SETUP_WAIT, ST_CHECK,
      ST_EMIT_MUL, ST_EMIT_START, ST_EMIT_WAIT, ST_EMIT_OUT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic signed [SW-1:0] held_l_ff, held_l_in, held_r_ff, held_r_in;
   logic [FCB-1:0]       j_ff, j_in;
   logic [TOT_W-1:0]     emitted_ff, emitted_in, total_ff, total_in;
   logic [FCB-1:0]       whole_ff, whole_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [RW-1:0]        srate_ff, srate_in;
   logic [STW-1:0]       step_whole_ff, step_whole_in;
   logic [RW-1:0]        step_rem_ff, step_rem_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 pick_cur_ff, pick_cur_in;
   logic signed [NW-1:0] pa_l_ff, pa_l_in, pb_l_ff, pb_l_in;
   logic signed [NW-1:0] pa_r_ff, pa_r_in, pb_r_ff, pb_r_in;
   logic                 neg_l_ff, neg_l_in, neg_r_ff, neg_r_in;
   logic [SW-1:0]        res_l_ff, res_l_in, res_r_ff, res_r_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 div0_start, div1_start, div0_done, div1_done;
   logic [DIV_W-1:0]     div0_dividend, div1_dividend, div0_quo, div1_quo;
   logic [RW-1:0]        div0_divisor, div1_divisor, div0_rem, div1_rem;

   logic signed [SW-1:0] cur_l, cur_r, fl, fr;
   logic signed [SW:0]   diff_l, diff_r;
   logic signed [RW:0]   out_s, rm_s;
   logic signed [NW-1:0] num_l, num_r;
   logic [NW-1:0]        mag_l, mag_r;
   logic [RW+4:0]        src_x24;
   logic [RW:0]          up_sum;
   logic [RW+13:0]       up_prod;
   logic [RW-1:0]        src_floor;
   logic                 needed_match;
   logic [RW:0]          sum_rem;
   logic                 carry;
   logic [RW-1:0]        rem_next;
   logic [ADV_W-1:0]     whole_next;
   logic [FCB-1:0]       n_minus1;

   lirs_div #(.DIV_W(DIV_W)) u_div0 (
      .clock(clock), .reset(reset), .start(div0_start), .dividend(div0_dividend),
      .divisor(div0_divisor), .done(div0_done), .quotient(div0_quo),
      .remainder(div0_rem)
   );

   lirs_div #(.DIV_W(DIV_W)) u_div1 (
      .clock(clock), .reset(reset), .start(div1_start), .dividend(div1_dividend),
      .divisor(div1_divisor), .done(div1_done), .quotient(div1_quo),
      .remainder(div1_rem)
   );

   always_comb begin
      cur_l   = head.entry.left;
      cur_r   = head.entry.right;
      fl      = pick_cur_ff ? cur_l : held_l_ff;
      fr      = pick_cur_ff ? cur_r : held_r_ff;
      diff_l  = (SW + 1)'(cur_l) - (SW + 1)'(fl);
      diff_r  = (SW + 1)'(cur_r) - (SW + 1)'(fr);
      out_s   = $signed({1'b0, eff_out});
      rm_s    = $signed({1'b0, rem_ff});
      num_l   = pa_l_ff + pb_l_ff;
      num_r   = pa_r_ff + pb_r_ff;
      mag_l   = num_l[NW-1] ? NW'(-num_l) : NW'(num_l);
      mag_r   = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
      src_x24 = (RW + 5)'(src_raw) * (RW + 5)'(lirs_pkg::MAX_UP_RATIO);
      up_sum  = {1'b0, eff_out} + (RW + 1)'(lirs_pkg::MAX_UP_RATIO - 1'b1);
      up_prod = (RW + 14)'(up_sum >> lirs_pkg::UP_RATIO_SHIFT)
                * (RW + 14)'(lirs_pkg::THIRD_RECIP);
      src_floor = RW'(up_prod >> lirs_pkg::THIRD_SHIFT);
      n_minus1 = frame_total - 1'b1;
      needed_match = (rem_ff == '0) ? (whole_ff == j_ff)
                                     : (({1'b0, whole_ff} + 1'b1) == {1'b0, j_ff});
      sum_rem  = {1'b0, rem_ff} + {1'b0, step_rem_ff};
      carry    = sum_rem >= {1'b0, eff_out};
      rem_next = carry ? RW'(sum_rem - {1'b0, eff_out}) : sum_rem[RW-1:0];
      whole_next = ADV_W'(whole_ff) + ADV_W'(step_whole_ff) + ADV_W'(carry);

      state_in      = state_ff;
      held_l_in     = held_l_ff;
      held_r_in     = held_r_ff;
      j_in          = j_ff;
      emitted_in    = emitted_ff;
      total_in      = total_ff;
      whole_in      = whole_ff;
      rem_in        = rem_ff;
      srate_in      = srate_ff;
      step_whole_in = step_whole_ff;
      step_rem_in   = step_rem_ff;
      count_in      = count_ff;
      prod_in       = prod_ff;
      pick_cur_in   = pick_cur_ff;
      pa_l_in       = pa_l_ff;
      pb_l_in       = pb_l_ff;
      pa_r_in       = pa_r_ff;
      pb_r_in       = pb_r_ff;
      neg_l_in      = neg_l_ff;
      neg_r_in      = neg_r_ff;
      res_l_in      = res_l_ff;
      res_r_in      = res_r_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      div0_start    = 1'b0;
      div1_start    = 1'b0;
      div0_dividend = '0;
      div1_dividend = '0;
      div0_divisor  = eff_out;
      div1_divisor  = eff_out;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               count_in = '0;
               if (head.entry.first) begin
                  j_in     = '0;
                  srate_in = (src_x24 < (RW + 5)'(eff_out)) ? src_floor : src_raw;
                  state_in = ST_MUL;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(frame_total) * PROD_W'(eff_out);
            state_in = ST_SETUP_START;
         end
         ST_SETUP_START: begin
            div0_start    = 1'b1;
            div0_dividend = DIV_W'(prod_ff) + DIV_W'(srate_ff >> 1);
            div0_divisor  = srate_ff;
            div1_start    = 1'b1;
            div1_dividend = DIV_W'(srate_ff);
            state_in      = ST_SETUP_WAIT;
         end
         ST_SETUP_WAIT: begin
            if (div0_done && div1_done) begin
               total_in      = (div0_quo[TOT_W-1:0] == '0) ? TOT_W'(1) : div0_quo[TOT_W-1:0];
               step_whole_in = div1_quo[STW-1:0];
               step_rem_in   = div1_rem;
               emitted_in    = '0;
               whole_in      = '0;
               rem_in        = '0;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (emitted_ff < total_ff && count_ff < lirs_pkg::MAX_RESULTS && needed_match) begin
               pick_cur_in = whole_ff == j_ff;
               state_in    = ST_EMIT_MUL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EMIT_MUL: begin
            pa_l_in  = fl * out_s;
            pb_l_in  = diff_l * rm_s;
            pa_r_in  = fr * out_s;
            pb_r_in  = diff_r * rm_s;
            state_in = ST_EMIT_START;
         end
         ST_EMIT_START: begin
            neg_l_in      = num_l[NW-1];
            neg_r_in      = num_r[NW-1];
            div0_start    = 1'b1;
            div0_dividend = DIV_W'(mag_l);
            div1_start    = 1'b1;
            div1_dividend = DIV_W'(mag_r);
            state_in      = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (div0_done && div1_done) begin
               res_l_in = neg_l_ff ? SW'(-div0_quo[SW-1:0]) : div0_quo[SW-1:0];
               res_r_in = neg_r_ff ? SW'(-div1_quo[SW-1:0]) : div1_quo[SW-1:0];
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_r_ff, res_l_ff};
               rsp_last_in  = TOT_W'(emitted_ff + 1'b1) == total_ff;
               emitted_in   = emitted_ff + 1'b1;
               count_in     = count_ff + 1'b1;
               if (whole_next >= ADV_W'(n_minus1)) begin
                  whole_in = n_minus1;
                  rem_in   = '0;
               end else begin
                  whole_in = whole_next[FCB-1:0];
                  rem_in   = rem_next;
               end
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            held_l_in = cur_l;
            held_r_in = cur_r;
            pop       = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         j_ff         <= '0;
         emitted_ff   <= '0;
         total_ff     <= '0;
         whole_ff     <= '0;
         rem_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_l_ff    <= held_l_in;
         held_r_ff    <= held_r_in;
         j_ff         <= j_in;
         emitted_ff   <= emitted_in;
         total_ff     <= total_in;
         whole_ff     <= whole_in;
         rem_ff       <= rem_in;
         count_ff     <= count_in;
      end
      srate_ff      <= srate_in;
      step_whole_ff <= step_whole_in;
      step_rem_ff   <= step_rem_in;
      prod_ff       <= prod_in;
      pick_cur_ff   <= pick_cur_in;
      pa_l_ff       <= pa_l_in;
      pb_l_ff       <= pb_l_in;
      pa_r_ff       <= pa_r_in;
      pb_r_ff       <= pb_r_in;
      neg_l_ff      <= neg_l_in;
      neg_r_ff      <= neg_r_in;
      res_l_ff      <= res_l_in;
      res_r_ff      <= res_r_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/linear_interp_stereo_resampler.sv */
// Top level of the linear interpolation stereo resampler.
// The block turns a clip of source frames into stereo output words at the output rate,
// interpolating linearly between neighboring frames with an exact remainder. Input words are
// taken into a two-word queue while it has room; the back end then works on one frame at a
// time. Each output word is divided out by the two bit-serial dividers (DIV_W =
// max(FRAME_COUNT_BITS + 19, 36), 43 at the default width), which run the left and right
// channels side by side. The first frame of a clip also carries a setup that derives the
// output count and the position step. A finished word waits in the output register while the
// next one is computed. Any configuration write restarts the clip at its first frame and must
// be made while idle.
module linear_interp_stereo_resampler #(
   parameter int FRAME_COUNT_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lirs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [((FRAME_COUNT_BITS > lirs_pkg::RATE_W) ? FRAME_COUNT_BITS
                  : lirs_pkg::RATE_W)-1:0]  csr_data,
   // Source frames.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // first_channel_sample, second_channel_sample
   // Output frames.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // left_out, right_out
   output logic        rsp_tlast
);

   localparam int CSR_DATA_W = (FRAME_COUNT_BITS > lirs_pkg::RATE_W) ? FRAME_COUNT_BITS
                               : lirs_pkg::RATE_W;

   logic                            push;
   lirs_pkg::req_entry_type         push_entry;
   logic                            queue_full;
   lirs_pkg::queue_head_type        head;
   logic                            pop;
   logic [lirs_pkg::RATE_W-1:0]     eff_out;
   logic [lirs_pkg::RATE_W-1:0]     src_raw;
   logic [FRAME_COUNT_BITS-1:0]     frame_total;

   lirs_front #(
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
      .CSR_DATA_W(CSR_DATA_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .push(push), .push_entry(push_entry), .queue_full(queue_full),
      .eff_out(eff_out), .src_raw(src_raw), .frame_total(frame_total)
   );

   lirs_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry),
      .full(queue_full), .head(head), .pop(pop)
   );

   lirs_back #(
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .eff_out(eff_out), .src_raw(src_raw), .frame_total(frame_total),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

/* rtl/lirs_checker.sv */
// Port-level checks of the resampler, attached to the top level by a bind.
module lirs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic seen_req_ff, seen_req_in;

   assign seen_req_in = seen_req_ff || (req_tvalid && req_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_req_ff <= 1'b0;
      end else begin
         seen_req_ff <= seen_req_in;
      end
   end

   // A stalled output word stays on the bus unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output word changed while stalled");

   // Reset empties the output register.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("output word valid right after reset");

   // Every output word follows at least one accepted source word.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> seen_req_ff)
      else $error("output word without any source word");

endmodule

bind linear_interp_stereo_resampler lirs_checker u_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

/* dv/linear_interp_stereo_resampler_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts the resampler output words and compares them with the DUT.
module linear_interp_stereo_resampler_checker #(
   parameter int FRAME_COUNT_BITS = 24,
   parameter int CSR_DATA_W = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [lirs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]            csr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [31:0]                      req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [31:0]                      rsp_tdata,
   input  logic                             rsp_tlast,
   output int                               words_awaited,
   output int                               mismatch_count
);

   typedef struct {
      logic signed [lirs_pkg::SAMPLE_W-1:0] left;
      logic signed [lirs_pkg::SAMPLE_W-1:0] right;
      logic                                 last;
   } stereo_word_type;

   stereo_word_type awaited_words[$];
   int error_tally = 0;

   logic [lirs_pkg::RATE_W-1:0] source_rate_reg;
   logic [lirs_pkg::RATE_W-1:0] output_rate_reg;
   logic [FRAME_COUNT_BITS-1:0] frame_count_reg;
   logic                        mono_reg;

   int              held_left;
   int              held_right;
   longint unsigned frames_in;
   longint unsigned words_out;
   longint unsigned words_in_clip;
   longint unsigned step_whole;
   int unsigned     step_rem;

   task automatic restart_clip();
      frames_in     = 0;
      words_out     = 0;
      words_in_clip = 0;
      step_whole    = 0;
      step_rem      = 0;
   endtask

   function automatic logic signed [15:0] blend(input int first, input int second,
                                                input int unsigned rem, input int unsigned rate);
      longint acc;
      acc = longint'(first) * longint'(rate) + longint'(second - first) * longint'(rem);
      return 16'(acc / longint'(rate));
   endfunction

   task automatic apply_register(input logic [lirs_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      case (index)
         lirs_pkg::CSR_SOURCE_RATE: source_rate_reg = value[lirs_pkg::RATE_W-1:0];
         lirs_pkg::CSR_OUTPUT_RATE: output_rate_reg = value[lirs_pkg::RATE_W-1:0];
         lirs_pkg::CSR_FRAME_COUNT: frame_count_reg = value[FRAME_COUNT_BITS-1:0];
         lirs_pkg::CSR_MONO_SOURCE: mono_reg = value[0];
         default: ;
      endcase
      restart_clip();
   endtask

   task automatic resample_frame(input logic signed [15:0] ch0, input logic signed [15:0] ch1);
      int unsigned     orate;
      int unsigned     srate;
      int unsigned     rm;
      int unsigned     sum;
      longint unsigned n;
      longint unsigned j;
      longint unsigned whole;
      longint unsigned needed;
      longint unsigned total;
      int              cur_left;
      int              cur_right;
      int              base_left;
      int              base_right;
      int              produced;
      stereo_word_type word;
      orate = (output_rate_reg < lirs_pkg::MIN_RATE || output_rate_reg > lirs_pkg::MAX_RATE)
              ? lirs_pkg::DEFAULT_RATE : output_rate_reg;
      srate = (source_rate_reg == 0) ? orate : source_rate_reg;
      if (srate * lirs_pkg::MAX_UP_RATIO < orate)
         srate = (orate + lirs_pkg::MAX_UP_RATIO - 1) / lirs_pkg::MAX_UP_RATIO;
      n = (frame_count_reg == 0) ? 1 : frame_count_reg;
      j = frames_in;
      cur_left = ch0;
      cur_right = mono_reg ? cur_left : int'(ch1);
      produced = 0;
      if (j == 0) begin
         total = (n * orate + srate / 2) / srate;
         words_in_clip = (total == 0) ? 1 : total;
         words_out = 0;
         step_whole = 0;
         step_rem = 0;
      end
      while (words_out < words_in_clip && produced < lirs_pkg::MAX_RESULTS) begin
         whole = step_whole;
         rm = step_rem;
         if (whole >= n - 1) begin
            whole = n - 1;
            rm = 0;
         end
         needed = (rm == 0) ? whole : whole + 1;
         if (needed != j) break;
         base_left = (whole == j) ? cur_left : held_left;
         base_right = (whole == j) ? cur_right : held_right;
         word.left = blend(base_left, cur_left, rm, orate);
         word.right = blend(base_right, cur_right, rm, orate);
         words_out++;
         word.last = (words_out == words_in_clip);
         awaited_words.insert(awaited_words.size(), word);
         produced++;
         sum = step_rem + srate;
         step_whole += sum / orate;
         step_rem = sum % orate;
         if (step_whole >= n - 1) begin
            step_whole = n - 1;
            step_rem = 0;
         end
      end
      held_left = cur_left;
      held_right = cur_right;
      frames_in = j + 1;
      if (frames_in >= n) restart_clip();
   endtask

   always @(posedge clock) begin : monitor
      stereo_word_type want;
      logic signed [15:0] got_left;
      logic signed [15:0] got_right;
      if (reset) begin
         source_rate_reg = '0;
         output_rate_reg = lirs_pkg::DEFAULT_RATE;
         frame_count_reg = 1;
         mono_reg = 1'b0;
         held_left = 0;
         held_right = 0;
         restart_clip();
         awaited_words.delete();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_tvalid && req_tready) resample_frame(req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready) begin
            got_left = rsp_tdata[15:0];
            got_right = rsp_tdata[31:16];
            if (awaited_words.size() == 0) begin
               $error("unexpected output word: left_out %0d, right_out %0d, clip_end %0b",
                      got_left, got_right, rsp_tlast);
               error_tally++;
            end else begin
               want = awaited_words.pop_front();
               if (got_left !== want.left) begin
                  $error("left_out mismatch: expected %0d, actual %0d", want.left, got_left);
                  error_tally++;
               end
               if (got_right !== want.right) begin
                  $error("right_out mismatch: expected %0d, actual %0d", want.right, got_right);
                  error_tally++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("clip_end mismatch: expected %0b, actual %0b", want.last, rsp_tlast);
                  error_tally++;
               end
            end
         end
      end
      words_awaited <= awaited_words.size();
      mismatch_count <= error_tally;
   end

endmodule

/* dv/linear_interp_stereo_resampler_tb.sv */
`timescale 1ns / 100ps
// Testbench top that drives clips and rate settings into the resampler and gives the verdict.
module linear_interp_stereo_resampler_tb;

   localparam int FRAME_COUNT_BITS = 24;
   localparam int CSR_DATA_W = (FRAME_COUNT_BITS > lirs_pkg::RATE_W) ? FRAME_COUNT_BITS
                               : lirs_pkg::RATE_W;
   localparam int RANDOM_ITEMS = 160;
   localparam int SETTLE_CYCLES = 300;
   localparam int RSP_HOLD_CYCLES = 800;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int unsigned RATE_MENU [10] = '{8000, 11025, 16000, 22050, 32000,
                                             44100, 48000, 88200, 96000, 192000};

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lirs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]            csr_data = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [31:0]                      req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [31:0]                      rsp_tdata;
   logic                             rsp_tlast;

   int words_awaited;
   int mismatch_count;
   int quiet_cycles = 0;
   bit pacing_on = 1'b1;
   bit hold_request = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   linear_interp_stereo_resampler #(
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   linear_interp_stereo_resampler_checker #(
      .FRAME_COUNT_BITS(FRAME_COUNT_BITS),
      .CSR_DATA_W      (CSR_DATA_W)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .words_awaited (words_awaited),
      .mismatch_count(mismatch_count)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : rsp_pacing
      int stall;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (pacing_on && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_for_drain(input int extra_cycles);
      @(posedge clock);
      while (words_awaited != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [lirs_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Upper data bits above a register's width are filled with noise; they must be ignored.
   task automatic configure(input int unsigned src, input int unsigned dst,
                            input int unsigned frames, input bit mono);
      req_tvalid <= 1'b0;
      wait_for_drain(SETTLE_CYCLES);
      write_register(lirs_pkg::CSR_SOURCE_RATE, {6'($urandom), 18'(src)});
      write_register(lirs_pkg::CSR_OUTPUT_RATE, {6'($urandom), 18'(dst)});
      write_register(lirs_pkg::CSR_FRAME_COUNT, 24'(frames));
      write_register(lirs_pkg::CSR_MONO_SOURCE, {23'($urandom), mono});
      csr_valid <= 1'b0;
   endtask

   task automatic offer_frame(input logic [15:0] ch0, input logic [15:0] ch1);
      int gap;
      if (pacing_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ch1, ch0};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample(input int unsigned style);
      logic [15:0] corners [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      case (style)
         0: return corners[$urandom_range(0, 3)];
         1: return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int unsigned pick_rate(input bit allow_zero);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (allow_zero && roll == 0) return 0;
      if (roll == 1) return $urandom_range(0, 262143);
      return RATE_MENU[$urandom_range(0, 9)];
   endfunction

   initial begin : stimulus
      int sent;
      int phase;
      int count;
      int style;
      int unsigned frames;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings after reset: one-frame clips at equal rates.
      offer_frame(16'h7fff, 16'h8000);
      offer_frame(16'h8000, 16'h7fff);

      configure(44100, 48000, 4, 1'b0);
      offer_frame(16'h7fff, 16'h8000);
      offer_frame(16'h8000, 16'h7fff);
      offer_frame(16'h0000, 16'hffff);
      offer_frame(16'hffff, 16'h0000);

      // Source rate far below the output rate is raised to a 24x ratio.
      configure(1, 192000, 2, 1'b1);
      offer_frame(16'h8000, 16'h1234);
      offer_frame(16'h7fff, 16'h8000);

      configure(192000, 8000, 6, 1'b0);
      repeat (6) offer_frame(pick_sample(2), pick_sample(2));

      // Out-of-range output rate with a huge clip, aborted by the next write.
      configure(262143, 262143, 24'hffffff, 1'b1);
      repeat (3) offer_frame(pick_sample(2), pick_sample(2));

      configure(0, 7999, 0, 1'b0);
      offer_frame(16'h7fff, 16'h0001);
      offer_frame(16'h8000, 16'hfffe);

      configure(192000, 192000, 3, 1'b0);
      repeat (3) offer_frame(pick_sample(0), pick_sample(0));

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pacing_on = (sent < RANDOM_ITEMS - 30) && ($urandom_range(0, 3) != 0);
         style = $urandom_range(0, 5);
         if (phase == 2) begin
            configure(8000, 192000, 8, 1'b0);
            pacing_on = 1'b0;
            hold_request = 1'b1;
            count = 8;
         end else begin
            frames = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24'hffffff)
                     : $urandom_range(0, 10);
            configure(pick_rate(1'b1), pick_rate(1'b0), frames, $urandom_range(0, 1));
            if (frames > 10) begin
               count = $urandom_range(1, 6);
            end else if (frames == 0) begin
               count = $urandom_range(1, 4);
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: count = frames;
                  5, 6: count = 2 * frames;
                  default: count = $urandom_range(1, frames);
               endcase
            end
         end
         repeat (count) offer_frame(pick_sample(style), pick_sample(style));
         sent += count;
         phase++;
      end
      req_tvalid <= 1'b0;
      pacing_on = 1'b0;

      wait_for_drain(SETTLE_CYCLES);
      if (mismatch_count == 0 && words_awaited == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lirs_pkg.sv
rtl/lirs_div.sv
rtl/lirs_queue.sv
rtl/lirs_front.sv
rtl/lirs_back.sv
rtl/linear_interp_stereo_resampler.sv
rtl/lirs_checker.sv
dv/linear_interp_stereo_resampler_checker.sv
dv/linear_interp_stereo_resampler_tb.sv
